// ===== sv/gpb_pkg.sv =====
// shared types, constants and index functions for the gshare predictor with btb
// no dependencies

package gpb_pkg;

  localparam int BTB_ENTRIES  = 1024;
  localparam int PHT_ENTRIES  = 256;
  localparam int HISTORY_BITS = 8;

  localparam int ADDR_W     = 64;
  localparam int BTB_IDX_W  = $clog2(BTB_ENTRIES);
  localparam int PHT_IDX_W  = $clog2(PHT_ENTRIES);
  localparam int HIST_EXT_W = (HISTORY_BITS > PHT_IDX_W) ? HISTORY_BITS : PHT_IDX_W;
  localparam int CLR_DEPTH  = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_COND   = 2'd1;
  localparam logic [1:0] KIND_UNCOND = 2'd2;

  localparam logic [1:0] CTR_MIN = 2'd0;
  localparam logic [1:0] CTR_MAX = 2'd3;

  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } gpb_state_t;

  typedef struct packed {
    logic              valid;
    logic              cond;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] target;
  } btb_entry_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] pc;
    logic              advance;
    logic [1:0]        branch_kind;
    logic              taken;
    logic [ADDR_W-1:0] actual_target;
  } gpb_req_t;

  function automatic logic [BTB_IDX_W-1:0] btb_row(input logic [ADDR_W-1:0] pc);
    return pc[BTB_IDX_W+1:2];
  endfunction

  // word index folded with the global history
  function automatic logic [PHT_IDX_W-1:0] pht_row(input logic [ADDR_W-1:0] pc,
                                                   input logic [HISTORY_BITS-1:0] hist);
    logic [HIST_EXT_W-1:0] hist_ext;
    hist_ext = HIST_EXT_W'(hist);
    return pc[PHT_IDX_W+1:2] ^ hist_ext[PHT_IDX_W-1:0];
  endfunction

endpackage

// ===== sv/gpb_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
// no package dependencies

module gpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/gshare_predictor_with_btb.sv =====
// top level: gshare direction predictor with a direct-mapped branch target buffer
// depends on gpb_pkg and gpb_ram

// For each request, in the cycle it is accepted the btb and the
// pattern table are read, and in the next cycle the registered read data is
// judged, the entries are written back and the result is loaded into the
// output register. A new request is taken once the previous one has left the
// lookup cycle and the output register is free or being drained, so a request
// is never taken while the previous one is still being looked up. After reset
// a clearing pass over CLR_DEPTH (1024) addresses zeroes the valid and
// conditional marks of the btb and the pattern counters; no request is
// accepted during it. Input tuser carries the request kind (0 predict,
// 1 update); output tuser flags whether a fetch address or a verdict is
// reported.

module gshare_predictor_with_btb
  import gpb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pc[63:0], advance[64], branch_kind[66:65], taken[67], actual_target[131:68]
  input  logic [135:0] in_tdata,
  // mode[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // next_pc[63:0], mispredicted[64]
  output logic [71:0]  out_tdata,
  // next_pc_valid[0], verdict_valid[1]
  output logic [1:0]   out_tuser
);

  localparam int OUT_PAD = 72 - ADDR_W - 1;

  gpb_state_t state_r, state_nxt;

  logic [CLR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  gpb_req_t                req_r;
  gpb_req_t                in_req;
  logic [PHT_IDX_W-1:0]    pht_idx_r;
  logic [BTB_IDX_W-1:0]    btb_idx_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] next_pc_r, next_pc_nxt;
  logic              next_pc_valid_r, next_pc_valid_nxt;
  logic              verdict_valid_r, verdict_valid_nxt;
  logic              mispredicted_r, mispredicted_nxt;

  logic in_acc;

  // memory ports
  logic                 btb_we;
  logic [BTB_IDX_W-1:0] btb_waddr;
  btb_entry_t           btb_wdata;
  logic [BTB_IDX_W-1:0] btb_raddr;
  btb_entry_t           btb_q;
  logic                 pht_we;
  logic [PHT_IDX_W-1:0] pht_waddr;
  logic [1:0]           pht_wdata;
  logic [PHT_IDX_W-1:0] pht_raddr;
  logic [1:0]           pht_q;

  logic hit;
  logic fill;

  // unpack the request
  assign in_req.mode          = in_tuser;
  assign in_req.pc            = in_tdata[63:0];
  assign in_req.advance       = in_tdata[64];
  assign in_req.branch_kind   = in_tdata[66:65];
  assign in_req.taken         = in_tdata[67];
  assign in_req.actual_target = in_tdata[131:68];

  // accept only when the output register will be free for the result of the lookup
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // reads are issued straight from the request bus
  assign btb_raddr = btb_row(in_req.pc);
  assign pht_raddr = pht_row(in_req.pc, hist_r);

  gpb_ram #(
    .WIDTH($bits(btb_entry_t)),
    .DEPTH(BTB_ENTRIES)
  ) u_btb_ram (
    .clk    (clk),
    .wr_en  (btb_we),
    .wr_addr(btb_waddr),
    .wr_data(btb_wdata),
    .rd_addr(btb_raddr),
    .rd_data(btb_q)
  );

  gpb_ram #(
    .WIDTH(2),
    .DEPTH(PHT_ENTRIES)
  ) u_pht_ram (
    .clk    (clk),
    .wr_en  (pht_we),
    .wr_addr(pht_waddr),
    .wr_data(pht_wdata),
    .rd_addr(pht_raddr),
    .rd_data(pht_q)
  );

  // lookup decisions on the registered read data
  assign hit  = btb_q.valid && (btb_q.tag == req_r.pc);
  assign fill = (req_r.mode == MODE_UPDATE) && req_r.taken && !btb_q.valid;

  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    hist_nxt          = hist_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    next_pc_nxt       = next_pc_r;
    next_pc_valid_nxt = next_pc_valid_r;
    verdict_valid_nxt = verdict_valid_r;
    mispredicted_nxt  = mispredicted_r;

    btb_we    = 1'b0;
    btb_waddr = btb_idx_r;
    btb_wdata = '{valid: 1'b1, cond: (req_r.branch_kind == KIND_COND),
                  tag: req_r.pc, target: req_r.actual_target};
    pht_we    = 1'b0;
    pht_waddr = pht_idx_r;
    pht_wdata = pht_q;

    unique case (state_r)
      ST_CLEAR: begin
        // sweep every entry back to invalid and strongly not taken
        btb_we    = 1'b1;
        btb_waddr = clr_cnt_r[BTB_IDX_W-1:0];
        btb_wdata = '0;
        pht_we    = 1'b1;
        pht_waddr = clr_cnt_r[PHT_IDX_W-1:0];
        pht_wdata = CTR_MIN;
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt         = ST_IDLE;
        out_valid_nxt     = 1'b1;
        next_pc_nxt       = '0;
        next_pc_valid_nxt = 1'b0;
        verdict_valid_nxt = 1'b0;
        mispredicted_nxt  = 1'b0;
        if (req_r.mode == MODE_PREDICT) begin
          if (hit && (!btb_q.cond || pht_q[1])) begin
            next_pc_nxt       = btb_q.target;
            next_pc_valid_nxt = 1'b1;
          end else if (req_r.advance) begin
            next_pc_nxt       = req_r.pc + ADDR_W'(4);
            next_pc_valid_nxt = 1'b1;
          end
        end else begin
          // conditional entries train without a tag compare
          if (btb_q.cond) begin
            pht_we            = 1'b1;
            verdict_valid_nxt = 1'b1;
            mispredicted_nxt  = pht_q[1] ^ req_r.taken;
            if (req_r.taken) begin
              if (pht_q != CTR_MAX) begin
                pht_wdata = pht_q + 2'd1;
              end
            end else begin
              if (pht_q != CTR_MIN) begin
                pht_wdata = pht_q - 2'd1;
              end
            end
          end
          if (req_r.branch_kind != KIND_UNCOND) begin
            hist_nxt = {hist_r[HISTORY_BITS-2:0], req_r.taken};
          end
          // only empty entries are filled; a conditional fill counts as a miss
          if (fill) begin
            btb_we = 1'b1;
            if (req_r.branch_kind == KIND_COND) begin
              verdict_valid_nxt = 1'b1;
              mispredicted_nxt  = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r     <= in_req;
      btb_idx_r <= btb_raddr;
      pht_idx_r <= pht_raddr;
    end
    next_pc_r       <= next_pc_nxt;
    next_pc_valid_r <= next_pc_valid_nxt;
    verdict_valid_r <= verdict_valid_nxt;
    mispredicted_r  <= mispredicted_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, mispredicted_r, next_pc_r};
  assign out_tuser  = {verdict_valid_r, next_pc_valid_r};

endmodule

// ===== bench/gpb_outcome_checker.sv =====
`timescale 1ns / 1ps
// checker for the gshare predictor with btb: watches both stream channels,
// predicts each result from its own copy of history, counters and btb, compares
// depends on gpb_pkg

module gpb_outcome_checker
  import gpb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [71:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  output int           mismatch_count,
  output int           outcomes_pending
);

  localparam logic [1:0] CTR_TAKEN = 2'd2;

  typedef struct {
    logic [ADDR_W-1:0] next_pc;
    logic              next_pc_valid;
    logic              verdict_valid;
    logic              mispredicted;
  } outcome_t;

  logic [HISTORY_BITS-1:0] history;
  logic [1:0]              counters  [PHT_ENTRIES];
  logic                    slot_valid[BTB_ENTRIES];
  logic                    slot_cond [BTB_ENTRIES];
  logic [ADDR_W-1:0]       slot_tag  [BTB_ENTRIES];
  logic [ADDR_W-1:0]       slot_dest [BTB_ENTRIES];
  outcome_t                awaited_outcomes[$];

  // works out the result of one request and trains the local copy
  function automatic outcome_t resolve_request(input logic mode, input logic [ADDR_W-1:0] pc,
                                               input logic advance, input logic [1:0] kind,
                                               input logic taken,
                                               input logic [ADDR_W-1:0] dest);
    logic [BTB_IDX_W-1:0] b;
    logic [PHT_IDX_W-1:0] p;
    logic [1:0]           ctr;
    outcome_t             o;
    b = pc[BTB_IDX_W+1:2];
    p = pc[PHT_IDX_W+1:2] ^ PHT_IDX_W'(history);
    o = '{next_pc: '0, next_pc_valid: 1'b0, verdict_valid: 1'b0, mispredicted: 1'b0};

    if (mode == MODE_PREDICT) begin
      if (slot_valid[b] && slot_tag[b] == pc && (!slot_cond[b] || counters[p] >= CTR_TAKEN)) begin
        o.next_pc       = slot_dest[b];
        o.next_pc_valid = 1'b1;
      end else if (advance) begin
        o.next_pc       = pc + 64'd4;
        o.next_pc_valid = 1'b1;
      end
      return o;
    end

    // conditional entries train without a tag compare
    if (slot_cond[b]) begin
      ctr = counters[p];
      o.verdict_valid = 1'b1;
      if (taken) begin
        if (ctr != CTR_MAX) counters[p] = ctr + 2'd1;
        o.mispredicted = (ctr < CTR_TAKEN);
      end else begin
        if (ctr != CTR_MIN) counters[p] = ctr - 2'd1;
        o.mispredicted = (ctr >= CTR_TAKEN);
      end
    end

    if (kind != KIND_UNCOND) history = {history[HISTORY_BITS-2:0], taken};

    if (taken && !slot_valid[b]) begin
      slot_valid[b] = 1'b1;
      slot_tag[b]   = pc;
      slot_dest[b]  = dest;
      slot_cond[b]  = (kind == KIND_COND);
      if (kind == KIND_COND) begin
        o.verdict_valid = 1'b1;
        o.mispredicted  = 1'b1;
      end
    end
    return o;
  endfunction

  task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      history = '0;
      foreach (counters[i]) counters[i] = CTR_MIN;
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_cond[i]  = 1'b0;
      end
      awaited_outcomes.delete();
      mismatch_count = 0;
    end else begin
      // results leave before the request of this edge can produce one
      if (out_tvalid && out_tready) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with none awaited, expected nothing, got tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("next_pc", want.next_pc, out_tdata[63:0]);
          check_field("mispredicted", ADDR_W'(want.mispredicted), ADDR_W'(out_tdata[64]));
          check_field("next_pc_valid", ADDR_W'(want.next_pc_valid), ADDR_W'(out_tuser[0]));
          check_field("verdict_valid", ADDR_W'(want.verdict_valid), ADDR_W'(out_tuser[1]));
        end
      end
      if (in_tvalid && in_tready)
        awaited_outcomes.push_back(resolve_request(in_tuser, in_tdata[63:0], in_tdata[64],
                                                   in_tdata[66:65], in_tdata[67],
                                                   in_tdata[131:68]));
    end
    outcomes_pending = awaited_outcomes.size();
  end

endmodule

// ===== bench/gshare_predictor_with_btb_tb.sv =====
`timescale 1ns / 1ps
// top of the bench for the gshare predictor with btb: clock, reset, request
// stimulus, receiver stalls and the verdict; depends on gpb_pkg, the block and
// gpb_outcome_checker

module gshare_predictor_with_btb_tb
  import gpb_pkg::*;
;

  // request budget and run limits
  localparam int          ITEMS        = 1950;
  localparam int          POOL         = 24;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 8;
  // clearing pass plus every request at its longest gap and stall, several times over
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // kind 3 is not named by the block; it behaves as other
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // fixed addresses for the directed part; the alias shares the btb slot of
  // the conditional branch but carries a different tag
  localparam logic [63:0] PC_JUMP     = 64'h0000_0000_0000_1000;
  localparam logic [63:0] PC_BRANCH   = 64'h8000_0000_0000_2004;
  localparam logic [63:0] PC_ALIAS    = 64'h4000_0000_0000_2004;
  localparam logic [63:0] PC_OTHER    = 64'h1234_5678_9abc_d0f8;
  localparam logic [63:0] PC_SPARE    = 64'hfedc_ba98_7654_3210;
  localparam logic [63:0] PC_NOTTAKEN = 64'h0000_00ff_0000_3ffc;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic [1:0]   out_tuser;

  int          mismatch_count;
  int          outcomes_pending;
  int          sent_count  = 0;
  int unsigned cycle_count = 0;

  // shared between the sender and the receiver
  bit hold_request = 1'b0;   // receiver holds off for a long stretch
  bit steady       = 1'b0;   // neither side idles
  bit burst        = 1'b0;   // sender offers back to back

  // branch addresses reused by the random part so that the btb actually hits
  logic [63:0] pool_pc    [POOL];
  logic [63:0] pool_target[POOL];
  logic [1:0]  pool_kind  [POOL];
  int          pool_bias  [POOL];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  gshare_predictor_with_btb DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  gpb_outcome_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .mismatch_count   (mismatch_count),
    .outcomes_pending (outcomes_pending)
  );

  // gap length: one draw in twenty takes the long range, the rest the short one
  function automatic int idle_cycles();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [63:0] any_address();
    return {$urandom(), $urandom()};
  endfunction

  // offers one request, called at a rising edge and returning at the edge
  // where it is taken; tvalid stays high unless a gap is drawn
  task automatic offer(input logic mode, input logic [63:0] pc, input logic advance,
                       input logic [1:0] kind, input logic taken, input logic [63:0] dest);
    if (!steady && !burst && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (idle_cycles()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    // pad, actual_target, taken, branch_kind, advance, pc (low bits last)
    in_tdata  <= {4'b0, dest, taken, kind, advance, pc};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // well-formed pair: fetch lookup then resolve of the same branch
  task automatic branch_pair(input int i);
    logic [1:0] kind;
    logic       taken;
    kind  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : pool_kind[i];
    taken = ($urandom_range(0, 99) < pool_bias[i]);
    offer(MODE_PREDICT, pool_pc[i], $urandom_range(0, 4) != 0, 2'($urandom()),
          1'($urandom()), any_address());
    offer(MODE_UPDATE, pool_pc[i], 1'($urandom()), kind, taken,
          taken ? pool_target[i] : any_address());
  endtask

  // receiver: ready stretches with random stalls, one long hold-off on request
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        if (!steady && $urandom_range(0, 2) == 0) begin
          out_tready <= 1'b0;
          repeat (idle_cycles()) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("** gshare_predictor_with_btb: FAILED **");
    $finish;
  end

  initial begin
    bit hold_done;
    bit pause_done;
    int k;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    // pool: every fourth entry aliases on the btb slot of the one before with a different tag
    for (k = 0; k < POOL; k++) begin
      pool_pc[k] = any_address();
      if (k % 4 == 1) pool_pc[k][11:0] = pool_pc[k-1][11:0];
      pool_pc[k][1:0] = 2'b00;
      pool_target[k]  = any_address();
      case ($urandom_range(0, 9))
        0, 1:    pool_kind[k] = KIND_UNCOND;
        2:       pool_kind[k] = KIND_OTHER;
        3:       pool_kind[k] = KIND_SPARE;
        default: pool_kind[k] = KIND_COND;
      endcase
      case ($urandom_range(0, 2))
        0:       pool_bias[k] = 10;
        1:       pool_bias[k] = 50;
        default: pool_bias[k] = 90;
      endcase
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    // lookup misses: no address without advance, pc plus four wraps with it
    offer(MODE_PREDICT, '0, 1'b0, KIND_OTHER, 1'b0, '0);
    offer(MODE_PREDICT, '1, 1'b1, KIND_UNCOND, 1'b1, '1);
    // unconditional fill, no history shift, then an unconditional hit
    offer(MODE_UPDATE, PC_JUMP, 1'b0, KIND_UNCOND, 1'b1, '1);
    offer(MODE_PREDICT, PC_JUMP, 1'b0, KIND_OTHER, 1'b0, '0);
    // conditional fill counts as a mispredict
    offer(MODE_UPDATE, PC_BRANCH, 1'b0, KIND_COND, 1'b1, '0);
    offer(MODE_PREDICT, PC_BRANCH, 1'b1, KIND_OTHER, 1'b0, '0);
    // train towards taken; the shifting history moves each update to another counter
    repeat (6) offer(MODE_UPDATE, PC_BRANCH, 1'b1, KIND_COND, 1'b1, '1);
    offer(MODE_PREDICT, PC_BRANCH, 1'b0, KIND_OTHER, 1'b0, '0);
    offer(MODE_UPDATE, PC_BRANCH, 1'b0, KIND_COND, 1'b0, '0);
    // aliasing update trains the conditional entry, lookup misses on the tag
    offer(MODE_UPDATE, PC_ALIAS, 1'b0, KIND_OTHER, 1'b1, any_address());
    offer(MODE_PREDICT, PC_ALIAS, 1'b0, KIND_OTHER, 1'b0, '0);
    // fills of kind other and of the spare kind become unconditional
    offer(MODE_UPDATE, PC_OTHER, 1'b0, KIND_OTHER, 1'b1, any_address());
    offer(MODE_PREDICT, PC_OTHER, 1'b1, KIND_OTHER, 1'b0, '0);
    offer(MODE_UPDATE, PC_SPARE, 1'b1, KIND_SPARE, 1'b1, any_address());
    offer(MODE_PREDICT, PC_SPARE, 1'b0, KIND_SPARE, 1'b1, '0);
    // not taken on an empty slot: history shifts, nothing is filled
    offer(MODE_UPDATE, PC_NOTTAKEN, 1'b0, KIND_COND, 1'b0, '1);
    // unconditional entry not taken: no verdict, no history shift
    offer(MODE_UPDATE, PC_JUMP, 1'b0, KIND_UNCOND, 1'b0, '0);
    // train towards not taken
    repeat (4) offer(MODE_UPDATE, PC_BRANCH, 1'b0, KIND_COND, 1'b0, '0);

    // random part
    while (sent_count < ITEMS) begin
      // receiver holds off while the sender keeps offering back to back
      if (!hold_done && sent_count >= 600) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
        burst        = 1'b1;
      end
      if (burst && sent_count >= 660) burst = 1'b0;

      // sender pauses until every outstanding result has been returned
      if (!pause_done && sent_count >= 1200) begin
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        // by the next edge the checker has counted the last request taken
        @(posedge clk);
        wait (outcomes_pending == 0);
        @(posedge clk);
      end

      steady = (sent_count >= 1400 && sent_count < 1600);

      if ($urandom_range(0, 99) < 85)
        branch_pair($urandom_range(0, POOL - 1));
      else
        offer(1'($urandom()), any_address(), 1'($urandom()), 2'($urandom_range(0, 3)),
              1'($urandom()), any_address());
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (outcomes_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** gshare_predictor_with_btb: PASSED **");
    else
      $display("** gshare_predictor_with_btb: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
sv/gpb_pkg.sv
sv/gpb_ram.sv
sv/gshare_predictor_with_btb.sv
bench/gpb_outcome_checker.sv
bench/gshare_predictor_with_btb_tb.sv
